// ===== design/mtrwg_pkg.sv =====
// Shared types, constants and helper functions for the MT19937 word generator.
`default_nettype none
package mtrwg_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned MT_WORDS = 624;
	localparam int unsigned MT_SHIFT = 397;
	localparam int unsigned CNT_W    = $clog2(MT_WORDS);

	localparam word_t MT_MATRIX   = 32'h9908_b0df;
	localparam word_t MT_HIGH_BIT = 32'h8000_0000;
	localparam word_t MT_LOW_BITS = 32'h7fff_ffff;
	localparam word_t TEMPER_B    = 32'h9d2c_5680;
	localparam word_t TEMPER_C    = 32'hefc6_0000;

	// LCG x' = 69069*x + 1, plus the two-step form x'' = 69069^2*x + 69070.
	localparam word_t LCG_MUL  = 32'd69069;
	localparam word_t LCG_INC  = 32'd1;
	localparam word_t LCG_MUL2 = 32'd475559465;
	localparam word_t LCG_INC2 = 32'd69070;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef enum logic {
		SEED_IDLE,
		SEED_FILL
	} seed_state_t;

	typedef struct packed {
		logic busy;
		logic shift;
	} seed_ctrl_t;

	function automatic word_t temper(input word_t v);
		word_t y;
		y = v;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic word_t twist(input word_t w0, input word_t w1, input word_t wf);
		word_t y;
		word_t v;
		y = (w0 & MT_HIGH_BIT) | (w1 & MT_LOW_BITS);
		v = wf ^ (y >> 1);
		if (y[0]) begin
			v = v ^ MT_MATRIX;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/mtrwg_cell.sv =====
// One state cell of the shift chain: holds a 32-bit word and takes its neighbor's word.
`default_nettype none
module mtrwg_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire mtrwg_pkg::word_t d,
	output mtrwg_pkg::word_t   q
);
	import mtrwg_pkg::*;

	word_t word_q;

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule
`default_nettype wire

// ===== design/mtrwg_seed_gen.sv =====
// Seed sequencer: runs the LCG and feeds one seeded word per cycle into the chain.
`default_nettype none
module mtrwg_seed_gen (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire mtrwg_pkg::word_t seed,
	output mtrwg_pkg::seed_ctrl_t ctrl,
	output mtrwg_pkg::word_t      word
);
	import mtrwg_pkg::*;

	seed_state_t state_q;
	seed_state_t state_nxt;
	logic [CNT_W-1:0] cnt_q;
	word_t x_q;
	word_t x_one;
	word_t x_two;
	logic last;

	// Two LCG steps from the same register: one for the low half, one to advance.
	assign x_one = x_q * LCG_MUL + LCG_INC;
	assign x_two = x_q * LCG_MUL2 + LCG_INC2;
	assign word  = {x_q[31:16], x_one[31:16]};
	assign last  = (cnt_q == CNT_W'(MT_WORDS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SEED_IDLE: begin
				if (load) begin
					state_nxt = SEED_FILL;
				end
			end
			SEED_FILL: begin
				if (last) begin
					state_nxt = SEED_IDLE;
				end
			end
			default: state_nxt = SEED_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			SEED_IDLE: ctrl = '0;
			SEED_FILL: begin
				ctrl.busy  = 1'b1;
				ctrl.shift = 1'b1;
			end
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				cnt_q <= '0;
			end else if (state_q == SEED_FILL) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= seed;
		end else if (state_q == SEED_FILL) begin
			x_q <= x_two;
		end
	end

endmodule
`default_nettype wire

// ===== design/mt19937_random_word_generator_core.sv =====
// Top level of the MT19937 word generator: cell chain, twist, tempering and output register.
`default_nettype none
//
// Usage
//   Command channel: drive op and seed with start high; the transfer happens at a
//   rising edge where start is high and busy is low.
//   op = OP_SEED loads a new seed. The block then raises busy while
//   the seed sequencer shifts one LCG-derived word per cycle into the cell chain.
//   A seed transfer returns no result.
//   op = OP_DRAW twists one word and returns it tempered on random_word with done
//   high for exactly one cycle, the cycle after the transfer.
//   Draws may follow in every cycle: one word per cycle, busy stays low.
//   The state is a ring of 624 cells that shift by one on every draw or seed step;
//   the twist reads cells 0, 1 and 397 and writes the new word into the last cell,
//   so the window always holds the most recent 624 words. The seed fill ends once
//   the sequencer has fed 624 words into the chain input.
//   The receiver cannot stall; each result must be taken in its done cycle.
//   Reset clears busy and done; the state words are undefined until a seed, and
//   draws must not be issued before the first seed.
//
module mt19937_random_word_generator_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             op,
	input  wire mtrwg_pkg::word_t seed,
	output logic                  done,
	output mtrwg_pkg::word_t      random_word
);
	import mtrwg_pkg::*;

	word_t      cell_q [MT_WORDS];
	word_t      twist_word;
	word_t      chain_in;
	word_t      seed_word;
	word_t      random_word_q;
	seed_ctrl_t seed_ctrl;
	logic       take;
	logic       draw;
	logic       load;
	logic       shift;
	logic       done_q;

	// Accept a command only while no seed fill runs.
	assign take = start && !busy;
	assign draw = take && (op == OP_DRAW);
	assign load = take && (op == OP_SEED);

	mtrwg_seed_gen u_seed_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.seed   (seed),
		.ctrl   (seed_ctrl),
		.word   (seed_word)
	);

	assign busy = seed_ctrl.busy;

	// New word from the oldest two cells and the far tap.
	assign twist_word = twist(cell_q[0], cell_q[1], cell_q[MT_SHIFT]);

	// During a fill the sequencer feeds the chain; otherwise the twist does.
	assign chain_in = seed_ctrl.shift ? seed_word : twist_word;
	assign shift    = seed_ctrl.shift || draw;

	for (genvar i = 0; i < MT_WORDS; i++) begin : g_cell
		if (i == MT_WORDS - 1) begin : g_tail
			mtrwg_cell u_cell (
				.clk (clk),
				.en  (shift),
				.d   (chain_in),
				.q   (cell_q[i])
			);
		end else begin : g_body
			mtrwg_cell u_cell (
				.clk (clk),
				.en  (shift),
				.d   (cell_q[i+1]),
				.q   (cell_q[i])
			);
		end
	end

	// Register the tempered word on each draw; done marks the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= draw;
		end
	end

	always_ff @(posedge clk) begin
		if (draw) begin
			random_word_q <= temper(twist_word);
		end
	end

	assign done        = done_q;
	assign random_word = random_word_q;

endmodule
`default_nettype wire
